/* rtl/value_sum_histogram_2d_macros.svh */
// Assertion helpers shared by the histogram modules.
`ifndef VALUE_SUM_HISTOGRAM_2D_MACROS_SVH
`define VALUE_SUM_HISTOGRAM_2D_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* rtl/vsh2d_pkg.sv */
package vsh2d_pkg;

  localparam int unsigned MAX_X_BINS  = 64;
  localparam int unsigned MAX_Y_BINS  = 64;
  localparam int unsigned XW          = (MAX_X_BINS > 1) ? $clog2(MAX_X_BINS) : 1;
  localparam int unsigned YW          = (MAX_Y_BINS > 1) ? $clog2(MAX_Y_BINS) : 1;
  localparam int unsigned BIN_TOTAL   = MAX_X_BINS * MAX_Y_BINS;
  localparam int unsigned ADDR_W      = (BIN_TOTAL > 1) ? $clog2(BIN_TOTAL) : 1;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned BCNT_W      = 7;

  localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_READ = 1'b1
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_EDGE  = 3'd0,
    CFG_X_SCALE = 3'd1,
    CFG_X_BINS  = 3'd2,
    CFG_Y_EDGE  = 3'd3,
    CFG_Y_SCALE = 3'd4,
    CFG_Y_BINS  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } back_state_e;

  typedef struct packed {
    act_e               action;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] sample_value;
    logic [5:0]         read_x_bin;
    logic [5:0]         read_y_bin;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         hit_x_bin;
    logic [5:0]         hit_y_bin;
    logic signed [47:0] bin_sum;
    logic [31:0]        bin_hits;
    logic [31:0]        total_events;
  } out_item_t;

  typedef struct packed {
    act_e               action;
    logic [XW-1:0]      bx;
    logic [YW-1:0]      by;
    logic signed [31:0] value;
  } queue_item_t;

endpackage

/* rtl/vsh2d_front.sv */
module vsh2d_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vsh2d_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vsh2d_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  vsh2d_pkg::in_item_t            in_data_i,
  input  logic                           accept_en_i,
  output logic                           q_valid_o,
  input  logic                           q_ready_i,
  output vsh2d_pkg::queue_item_t         q_data_o
);
  import vsh2d_pkg::*;

  typedef struct packed {
    act_e               action;
    logic               x_pos;
    logic [31:0]        x_mag;
    logic               y_pos;
    logic [31:0]        y_mag;
    logic [XW-1:0]      rx;
    logic [YW-1:0]      ry;
    logic signed [31:0] value;
  } s1_t;

  typedef struct packed {
    act_e               action;
    logic               x_pos;
    logic [31:0]        x_hi;
    logic               y_pos;
    logic [31:0]        y_hi;
    logic [XW-1:0]      rx;
    logic [YW-1:0]      ry;
    logic signed [31:0] value;
  } s2_t;

  logic [31:0]       x_edge_q, x_scale_q, y_edge_q, y_scale_q;
  logic [BCNT_W-1:0] x_bins_q, y_bins_q;

  logic s1_valid_q, s2_valid_q, adv, in_fire;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;

  logic [32:0] dx, dy;
  logic [63:0] prod_x, prod_y;
  logic [31:0] eff_x, eff_y;

  // A bin count of zero behaves as one bin; anything above storage is capped.
  function automatic logic [31:0] eff_bins(logic [BCNT_W-1:0] n, logic [31:0] maxn);
    logic [31:0] w;
    w = 32'(n);
    if (w == 32'd0) begin
      return 32'd1;
    end
    return (w > maxn) ? maxn : w;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_edge_q  <= '0;
      x_scale_q <= 32'd65536;
      x_bins_q  <= BCNT_W'(64);
      y_edge_q  <= '0;
      y_scale_q <= 32'd65536;
      y_bins_q  <= BCNT_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_X_EDGE:  x_edge_q  <= cfg_wdata_i;
        CFG_X_SCALE: x_scale_q <= cfg_wdata_i;
        CFG_X_BINS:  x_bins_q  <= cfg_wdata_i[BCNT_W-1:0];
        CFG_Y_EDGE:  y_edge_q  <= cfg_wdata_i;
        CFG_Y_SCALE: y_scale_q <= cfg_wdata_i;
        CFG_Y_BINS:  y_bins_q  <= cfg_wdata_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipe holds while the last stage cannot hand its item to the queue.
  assign adv        = !(s2_valid_q && !q_ready_i);
  assign in_ready_o = adv && accept_en_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Stage one: exact 33-bit distance from the lower edge, and read bin indices clamped to storage.
  always_comb begin
    dx = {in_data_i.x_coord[31], in_data_i.x_coord} - {x_edge_q[31], x_edge_q};
    dy = {in_data_i.y_coord[31], in_data_i.y_coord} - {y_edge_q[31], y_edge_q};
    s1_d.action = in_data_i.action;
    s1_d.x_pos  = !dx[32] && (dx[31:0] != 32'd0);
    s1_d.x_mag  = dx[31:0];
    s1_d.y_pos  = !dy[32] && (dy[31:0] != 32'd0);
    s1_d.y_mag  = dy[31:0];
    s1_d.value  = in_data_i.sample_value;
    if (32'(in_data_i.read_x_bin) >= MAX_X_BINS) begin
      s1_d.rx = XW'(MAX_X_BINS - 1);
    end else begin
      s1_d.rx = XW'(in_data_i.read_x_bin);
    end
    if (32'(in_data_i.read_y_bin) >= MAX_Y_BINS) begin
      s1_d.ry = YW'(MAX_Y_BINS - 1);
    end else begin
      s1_d.ry = YW'(in_data_i.read_y_bin);
    end
  end

  // Stage two: scale by the reciprocal bin width and keep the integer part.
  assign prod_x = s1_q.x_mag * x_scale_q;
  assign prod_y = s1_q.y_mag * y_scale_q;

  always_comb begin
    s2_d.action = s1_q.action;
    s2_d.x_pos  = s1_q.x_pos;
    s2_d.x_hi   = prod_x[63:32];
    s2_d.y_pos  = s1_q.y_pos;
    s2_d.y_hi   = prod_y[63:32];
    s2_d.rx     = s1_q.rx;
    s2_d.ry     = s1_q.ry;
    s2_d.value  = s1_q.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_fire;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  // Clamp add items into the configured range before they go to the queue; reads keep their bin.
  assign eff_x = eff_bins(x_bins_q, MAX_X_BINS);
  assign eff_y = eff_bins(y_bins_q, MAX_Y_BINS);

  always_comb begin
    q_data_o.action = s2_q.action;
    q_data_o.value  = s2_q.value;
    if (s2_q.action == ACT_READ) begin
      q_data_o.bx = s2_q.rx;
      q_data_o.by = s2_q.ry;
    end else begin
      if (!s2_q.x_pos) begin
        q_data_o.bx = '0;
      end else if (s2_q.x_hi >= eff_x) begin
        q_data_o.bx = XW'(eff_x - 32'd1);
      end else begin
        q_data_o.bx = s2_q.x_hi[XW-1:0];
      end
      if (!s2_q.y_pos) begin
        q_data_o.by = '0;
      end else if (s2_q.y_hi >= eff_y) begin
        q_data_o.by = YW'(eff_y - 32'd1);
      end else begin
        q_data_o.by = s2_q.y_hi[YW-1:0];
      end
    end
  end

  assign q_valid_o = s2_valid_q;

endmodule

/* rtl/vsh2d_queue.sv */
`include "value_sum_histogram_2d_macros.svh"

module vsh2d_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  input  vsh2d_pkg::queue_item_t push_data_i,
  output logic                   pop_valid_o,
  input  logic                   pop_ready_i,
  output vsh2d_pkg::queue_item_t pop_data_o
);
  import vsh2d_pkg::*;

  queue_item_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push_fire, pop_fire;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push_fire && !pop_fire) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_fire) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      entries[wr_ptr_q] <= push_data_i;
    end
  end

  `VSH_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH))
  `VSH_ASSERT_NEXT(a_count_grows, clk_i, rst_ni, push_fire && !pop_fire, count_q == $past(count_q) + QCNT_W'(1))

endmodule

/* rtl/vsh2d_back.sv */
`include "value_sum_histogram_2d_macros.svh"

module vsh2d_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  vsh2d_pkg::queue_item_t pop_data_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output vsh2d_pkg::out_item_t   out_data_o
);
  import vsh2d_pkg::*;

  typedef struct packed {
    logic signed [47:0] sum;
    logic [31:0]        hits;
  } bin_entry_t;

  bin_entry_t bin_mem [BIN_TOTAL];

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [31:0]       total_q, total_new;
  logic              out_valid_q, out_free, load_out;
  out_item_t         out_q;
  queue_item_t       item_q;
  bin_entry_t        rd_data_q, upd_entry, mem_wdata;
  logic              mem_we, rd_en, clr_last;
  logic [ADDR_W-1:0] mem_waddr, rd_addr, item_addr;
  logic [48:0]       sum_wide;

  function automatic logic [ADDR_W-1:0] bin_addr(logic [XW-1:0] bx, logic [YW-1:0] by);
    return ADDR_W'(bx) * ADDR_W'(MAX_Y_BINS) + ADDR_W'(by);
  endfunction

  assign clr_last  = (clr_cnt_q == ADDR_W'(BIN_TOTAL - 1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign rd_addr   = bin_addr(pop_data_i.bx, pop_data_i.by);
  assign item_addr = bin_addr(item_q.bx, item_q.by);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR:  if (clr_last) state_d = BK_IDLE;
      BK_IDLE:   if (pop_valid_i) state_d = BK_UPDATE;
      BK_UPDATE: if (out_free) state_d = BK_IDLE;
      default:   state_d = BK_CLEAR;
    endcase
  end

  // Saturating read-modify-write of the addressed bin.
  always_comb begin
    sum_wide = {rd_data_q.sum[47], rd_data_q.sum} + {{17{item_q.value[31]}}, item_q.value};
    if (sum_wide[48] != sum_wide[47]) begin
      upd_entry.sum = sum_wide[48] ? SUM_MIN : SUM_MAX;
    end else begin
      upd_entry.sum = sum_wide[47:0];
    end
    upd_entry.hits = (rd_data_q.hits == '1) ? rd_data_q.hits : rd_data_q.hits + 32'd1;
    total_new      = (total_q == '1) ? total_q : total_q + 32'd1;
  end

  always_comb begin
    pop_ready_o = 1'b0;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = item_addr;
    mem_wdata   = upd_entry;
    load_out    = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      BK_IDLE: begin
        pop_ready_o = 1'b1;
        rd_en       = pop_valid_i;
      end
      BK_UPDATE: begin
        load_out = out_free;
        mem_we   = out_free && (item_q.action == ACT_ADD);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_cnt_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (load_out && item_q.action == ACT_ADD) begin
        total_q <= total_new;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      item_q <= pop_data_i;
    end
    if (load_out) begin
      out_q.hit_x_bin <= 6'(item_q.bx);
      out_q.hit_y_bin <= 6'(item_q.by);
      if (item_q.action == ACT_ADD) begin
        out_q.bin_sum      <= upd_entry.sum;
        out_q.bin_hits     <= upd_entry.hits;
        out_q.total_events <= total_new;
      end else begin
        out_q.bin_sum      <= rd_data_q.sum;
        out_q.bin_hits     <= rd_data_q.hits;
        out_q.total_events <= total_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= bin_mem[rd_addr];
    end
  end

  assign ready_o     = (state_q != BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `VSH_ASSERT_IMPL(a_no_pop_in_clear, clk_i, rst_ni, state_q == BK_CLEAR, !pop_ready_o && !out_valid_q)
  `VSH_ASSERT_NEXT(a_pop_then_update, clk_i, rst_ni, rd_en, state_q == BK_UPDATE)
  `VSH_ASSERT_NEXT(a_total_monotonic, clk_i, rst_ni, 1'b1, total_q >= $past(total_q))

endmodule

/* rtl/value_sum_histogram_2d.sv */
// When nothing stalls, an accepted item passes the second front stage, the queue write, the
// bin read and the bin update before its result is offered.
// The back end takes no new item from the queue while it does the read-modify-write of the last.
// Reset: all bins and the event total clear; after reset a sweep over all 4096 bins zeroes
// the bin memory, during which no item is accepted. Config resets to zero edges, scale 65536.
module value_sum_histogram_2d (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vsh2d_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vsh2d_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vsh2d_pkg::in_item_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vsh2d_pkg::out_item_t            out_data_o
);
  import vsh2d_pkg::*;

  logic        q_push_valid, q_push_ready, q_pop_valid, q_pop_ready, back_ready;
  queue_item_t q_push_data, q_pop_data;

  vsh2d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .accept_en_i (back_ready),
    .q_valid_o   (q_push_valid),
    .q_ready_i   (q_push_ready),
    .q_data_o    (q_push_data)
  );

  vsh2d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  vsh2d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .ready_o     (back_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
